// ===== src/dcws_pkg.sv =====
// ----------------------------------------------------------------------------
// dcws_pkg
// Shared widths, constants, pipeline record and arithmetic helpers for the
// duty-cycle wake scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dcws_pkg;

  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int TodW    = 11;
  localparam int CountW  = 11;
  localparam int OffW    = 16;
  localparam int SumW    = 17;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 11;

  localparam int MinutesPerHour = 60;
  localparam int MinutesPerDay  = 24 * MinutesPerHour;

  // minute split by reciprocal multiply
  localparam int RecipShift = 16;
  localparam int Recip60    = ((1 << RecipShift) + MinutesPerHour - 1) / MinutesPerHour;
  localparam int ProdW      = TodW + RecipShift - 1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgWinStartHour   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWinStartMinute = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWinEndHour     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWinEndMinute   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRunMinutes     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCycleMinutes   = 3'd5;

  // pipeline layout
  localparam int StIn        = 0;
  localparam int StPre       = 1;
  localparam int DivPerStage = 2;
  localparam int DivStages   = OffW / DivPerStage;
  localparam int DivFirst    = StPre + 1;
  localparam int DivLast     = DivFirst + DivStages - 1;
  localparam int StRun       = DivLast + 1;
  localparam int ModSteps    = 6;
  localparam int ModPerStage = 3;
  localparam int StModA      = StRun + 1;
  localparam int StModB      = StModA + 1;
  localparam int StQuot      = StModB + 1;
  localparam int NumStages   = StQuot + 1;

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [TodW-1:0]    now;
    logic               in_win;
    logic [OffW-1:0]    offset;
    logic [CountW-1:0]  rem;
    logic               active;
    logic [SumW-1:0]    acc;
    logic [HourW-1:0]   quot;
  } pipe_t;

  function automatic logic [TodW-1:0] tod_minutes(input logic [HourW-1:0] h,
                                                 input logic [MinuteW-1:0] m);
    logic [TodW-1:0] hx;
    hx = TodW'(h);
    return (hx << 6) - (hx << 2) + TodW'(m);
  endfunction

  // one restoring division step, remainder stays below the divisor
  function automatic logic [CountW-1:0] div_step(input logic [CountW-1:0] rem,
                                                input logic dbit,
                                                input logic [CountW-1:0] dvsr);
    logic [CountW:0] t;
    logic [CountW:0] d;
    t = {rem, dbit};
    d = {1'b0, dvsr};
    if (t >= d) begin
      t = t - d;
    end
    return t[CountW-1:0];
  endfunction

  // conditional subtract of one day scaled by 2^k
  function automatic logic [SumW-1:0] mod_step(input logic [SumW-1:0] x, input int k);
    logic [SumW-1:0] d;
    d = SumW'(MinutesPerDay) << k;
    if (x >= d) begin
      x = x - d;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== src/duty_cycle_wake_scheduler.sv =====
// ----------------------------------------------------------------------------
// duty_cycle_wake_scheduler
// Daily window check and duty-cycle next-wake computation per time-of-day beat.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat accepted per clock while in_stall is low. The
// pipeline holds the 16-bit restoring division of the window offset by the
// cycle length, two quotient bits per stage over eight stages, followed by a
// six-step modulo-1440 reduction and a reciprocal split into hour and minute.
// Bubbles collapse, so beats keep entering while a finished result waits on
// out_stall. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while nothing is in flight, the block does not enforce it.
`default_nettype none

module duty_cycle_wake_scheduler
  import dcws_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]    cfg_data,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [HourW-1:0]   in_hour_of_day,
  input  wire logic [MinuteW-1:0] in_minute_of_hour,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_wake_now,
  output logic                    out_in_window,
  output logic [HourW-1:0]        out_next_hour,
  output logic [MinuteW-1:0]      out_next_minute
);

  logic [HourW-1:0]   win_start_hour_r;
  logic [MinuteW-1:0] win_start_minute_r;
  logic [HourW-1:0]   win_end_hour_r;
  logic [MinuteW-1:0] win_end_minute_r;
  logic [CountW-1:0]  run_minutes_r;
  logic [CountW-1:0]  cycle_minutes_r;

  pipe_t              pipe_r   [NumStages];
  pipe_t              pipe_nxt [NumStages];
  logic [NumStages-1:0] valid_r;
  logic [NumStages-1:0] ready;

  logic               out_valid_r;
  logic               out_wake_now_r;
  logic               out_in_window_r;
  logic [HourW-1:0]   out_next_hour_r;
  logic [MinuteW-1:0] out_next_minute_r;
  logic               out_ready;

  logic [TodW-1:0]    start_tod;
  logic [TodW-1:0]    end_tod;
  logic [CountW-1:0]  cycle_eff;

  logic               wake_nxt;
  logic [HourW-1:0]   next_hour_nxt;
  logic [MinuteW-1:0] next_minute_nxt;
  logic [TodW-1:0]    quot60;
  logic [TodW-1:0]    min_rem;
  logic [ProdW-1:0]   prod;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_hour_r   <= HourW'(8);
      win_start_minute_r <= '0;
      win_end_hour_r     <= HourW'(20);
      win_end_minute_r   <= '0;
      run_minutes_r      <= CountW'(5);
      cycle_minutes_r    <= CountW'(60);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgWinStartHour:   win_start_hour_r   <= cfg_data[HourW-1:0];
        CfgWinStartMinute: win_start_minute_r <= cfg_data[MinuteW-1:0];
        CfgWinEndHour:     win_end_hour_r     <= cfg_data[HourW-1:0];
        CfgWinEndMinute:   win_end_minute_r   <= cfg_data[MinuteW-1:0];
        CfgRunMinutes:     run_minutes_r      <= cfg_data[CountW-1:0];
        CfgCycleMinutes:   cycle_minutes_r    <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign start_tod = tod_minutes(win_start_hour_r, win_start_minute_r);
  assign end_tod   = tod_minutes(win_end_hour_r, win_end_minute_r);
  assign cycle_eff = (cycle_minutes_r == '0) ? CountW'(1) : cycle_minutes_r;

  // flow control, bubbles collapse
  assign out_ready = !out_valid_r || !out_stall;

  always_comb begin
    ready[NumStages-1] = !valid_r[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  assign in_stall = !ready[StIn];

  // stage logic
  always_comb begin
    pipe_t t;

    // capture
    t        = pipe_r[StIn];
    t.hour   = in_hour_of_day;
    t.minute = in_minute_of_hour;
    t.now    = tod_minutes(in_hour_of_day, in_minute_of_hour);
    pipe_nxt[StIn] = t;

    // window check and offset
    t = pipe_r[StIn];
    if (start_tod <= end_tod) begin
      t.in_win = (start_tod <= t.now) && (t.now <= end_tod);
    end else begin
      t.in_win = (start_tod <= t.now) || (t.now <= end_tod);
    end
    if ((start_tod <= end_tod) || (t.now >= start_tod)) begin
      t.offset = OffW'(t.now) - OffW'(start_tod);
    end else begin
      t.offset = OffW'(MinutesPerDay) - OffW'(start_tod) + OffW'(t.now);
    end
    t.rem = '0;
    pipe_nxt[StPre] = t;

    // offset mod cycle
    for (int j = 0; j < DivStages; j++) begin
      t = pipe_r[DivFirst+j-1];
      for (int s = 0; s < DivPerStage; s++) begin
        t.rem = div_step(t.rem, t.offset[OffW-1-j*DivPerStage-s], cycle_eff);
      end
      pipe_nxt[DivFirst+j] = t;
    end

    // run check and start of next cycle
    t        = pipe_r[DivLast];
    t.active = t.rem < run_minutes_r;
    t.acc    = SumW'(start_tod) + SumW'(t.offset) + SumW'(cycle_eff) - SumW'(t.rem);
    pipe_nxt[StRun] = t;

    // reduce modulo one day
    t = pipe_r[StRun];
    for (int k = ModSteps - 1; k >= ModSteps - ModPerStage; k--) begin
      t.acc = mod_step(t.acc, k);
    end
    pipe_nxt[StModA] = t;

    t = pipe_r[StModA];
    for (int k = ModSteps - ModPerStage - 1; k >= 0; k--) begin
      t.acc = mod_step(t.acc, k);
    end
    pipe_nxt[StModB] = t;

    // hour of next wake
    t      = pipe_r[StModB];
    prod   = ProdW'(t.acc[TodW-1:0]) * ProdW'(Recip60);
    t.quot = prod[RecipShift +: HourW];
    pipe_nxt[StQuot] = t;
  end

  // result select
  always_comb begin
    quot60  = (TodW'(pipe_r[StQuot].quot) << 6) - (TodW'(pipe_r[StQuot].quot) << 2);
    min_rem = pipe_r[StQuot].acc[TodW-1:0] - quot60;
    if (!pipe_r[StQuot].in_win) begin
      next_hour_nxt   = win_start_hour_r;
      next_minute_nxt = win_start_minute_r;
    end else if (pipe_r[StQuot].active) begin
      next_hour_nxt   = pipe_r[StQuot].hour;
      next_minute_nxt = pipe_r[StQuot].minute;
    end else begin
      next_hour_nxt   = pipe_r[StQuot].quot;
      next_minute_nxt = min_rem[MinuteW-1:0];
    end
    wake_nxt = (pipe_r[StQuot].hour == next_hour_nxt) &&
               (pipe_r[StQuot].minute == next_minute_nxt);
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ready[StIn]) begin
        valid_r[StIn] <= in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (ready[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ready[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= valid_r[NumStages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_wake_now_r    <= wake_nxt;
      out_in_window_r   <= pipe_r[StQuot].in_win;
      out_next_hour_r   <= next_hour_nxt;
      out_next_minute_r <= next_minute_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_wake_now    = out_wake_now_r;
  assign out_in_window   = out_in_window_r;
  assign out_next_hour   = out_next_hour_r;
  assign out_next_minute = out_next_minute_r;

endmodule

`default_nettype wire

// ===== bench/duty_cycle_wake_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// duty_cycle_wake_scheduler_tb
// Self-checking bench for the duty-cycle wake scheduler. Time-of-day beats go
// in under random bursts and gaps while the result side stalls on its own
// pattern, once for a long stretch. Each accepted beat is predicted against a
// local copy of the window and duty-cycle registers. Results are compared
// field by field, in order. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module duty_cycle_wake_scheduler_tb
  import dcws_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LongHold      = 300;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 20;
  localparam int RandomPhases  = 14;
  localparam int PhaseBeats    = 118;
  localparam int MismatchPrint = 40;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPattern} stall_mode_t;

  typedef struct {
    logic               wake_now;
    logic               in_window;
    logic [HourW-1:0]   next_hour;
    logic [MinuteW-1:0] next_minute;
  } wake_result_t;

  class wake_scoreboard;
    logic [HourW-1:0]   start_hour;
    logic [MinuteW-1:0] start_minute;
    logic [HourW-1:0]   stop_hour;
    logic [MinuteW-1:0] stop_minute;
    logic [CountW-1:0]  run_len;
    logic [CountW-1:0]  cycle_len;
    wake_result_t       expected_wakes[$];
    int                 mismatches;
    int                 checked;
    int                 inside_hits;
    int                 wake_hits;

    function new();
      start_hour   = 5'd8;
      start_minute = 6'd0;
      stop_hour    = 5'd20;
      stop_minute  = 6'd0;
      run_len      = 11'd5;
      cycle_len    = 11'd60;
      mismatches   = 0;
      checked      = 0;
      inside_hits  = 0;
      wake_hits    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgWinStartHour:   start_hour   = data[HourW-1:0];
        CfgWinStartMinute: start_minute = data[MinuteW-1:0];
        CfgWinEndHour:     stop_hour    = data[HourW-1:0];
        CfgWinEndMinute:   stop_minute  = data[MinuteW-1:0];
        CfgRunMinutes:     run_len      = data[CountW-1:0];
        CfgCycleMinutes:   cycle_len    = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned start_of_day();
      return int'(start_hour) * MinutesPerHour + int'(start_minute);
    endfunction

    function int unsigned cycle_step();
      return (cycle_len == 0) ? 1 : int'(cycle_len);
    endfunction

    function wake_result_t next_wake(logic [HourW-1:0] h, logic [MinuteW-1:0] m);
      int unsigned now_min;
      int unsigned start_min;
      int unsigned end_min;
      int unsigned step;
      int unsigned offset;
      int unsigned base_off;
      int unsigned base;
      int unsigned nt;
      bit          win_hit;
      wake_result_t r;
      now_min   = int'(h) * MinutesPerHour + int'(m);
      start_min = start_of_day();
      end_min   = int'(stop_hour) * MinutesPerHour + int'(stop_minute);
      step      = cycle_step();
      if (start_min <= end_min) begin
        win_hit = (start_min <= now_min) && (now_min <= end_min);
      end else begin
        win_hit = (start_min <= now_min) || (now_min <= end_min);
      end
      if (!win_hit) begin
        r.next_hour   = start_hour;
        r.next_minute = start_minute;
      end else begin
        if (start_min <= end_min || now_min >= start_min) begin
          offset = (now_min - start_min) & 32'hFFFF;
        end else begin
          offset = (MinutesPerDay - start_min + now_min) & 32'hFFFF;
        end
        base_off = (offset / step) * step;
        base     = (start_min + base_off) % MinutesPerDay;
        if (offset - base_off < int'(run_len)) begin
          r.next_hour   = h;
          r.next_minute = m;
        end else begin
          nt            = (base + step) % MinutesPerDay;
          r.next_hour   = HourW'(nt / MinutesPerHour);
          r.next_minute = MinuteW'(nt % MinutesPerHour);
        end
      end
      r.in_window = win_hit;
      r.wake_now  = (h == r.next_hour) && (m == r.next_minute);
      return r;
    endfunction

    function void note_time(logic [HourW-1:0] h, logic [MinuteW-1:0] m);
      expected_wakes.push_back(next_wake(h, m));
    endfunction

    function int pending();
      return expected_wakes.size();
    endfunction

    task report_mismatch(string what);
      if (mismatches < MismatchPrint) begin
        $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatches++;
    endtask

    task check_result(logic w, logic i, logic [HourW-1:0] nh, logic [MinuteW-1:0] nm);
      wake_result_t e;
      if (expected_wakes.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = expected_wakes.pop_front();
        checked++;
        if (e.in_window) inside_hits++;
        if (e.wake_now) wake_hits++;
        if (w !== e.wake_now)
          report_mismatch($sformatf("wake_now got %b exp %b", w, e.wake_now));
        if (i !== e.in_window)
          report_mismatch($sformatf("in_window got %b exp %b", i, e.in_window));
        if (nh !== e.next_hour)
          report_mismatch($sformatf("next_hour got %0d exp %0d", nh, e.next_hour));
        if (nm !== e.next_minute)
          report_mismatch($sformatf("next_minute got %0d exp %0d", nm, e.next_minute));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [HourW-1:0]   in_hour_of_day = '0;
  logic [MinuteW-1:0] in_minute_of_hour = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_wake_now;
  logic               out_in_window;
  logic [HourW-1:0]   out_next_hour;
  logic [MinuteW-1:0] out_next_minute;

  wake_scoreboard sb = new();
  bit             hold_request = 1'b0;
  int             long_holds = 0;
  int             settings_applied = 0;

  duty_cycle_wake_scheduler DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_hour_of_day    (in_hour_of_day),
    .in_minute_of_hour (in_minute_of_hour),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_wake_now      (out_wake_now),
    .out_in_window     (out_in_window),
    .out_next_hour     (out_next_hour),
    .out_next_minute   (out_next_minute)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_wake_now, out_in_window, out_next_hour, out_next_minute);
    end
  end

  // result side stall pattern, with one long hold on request
  initial begin
    stall_mode_t mode;
    int          span;
    mode = StallNone;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        long_holds++;
        out_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
      end
      if (span == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(10, 200);
      end
      span--;
      case (mode)
        StallNone:    out_stall <= 1'b0;
        StallLight:   out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy:   out_stall <= ($urandom_range(0, 3) != 0);
        default:      out_stall <= ((span % 8) < 3);
      endcase
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
             WatchdogLimit, sb.pending());
    $display("** duty_cycle_wake_scheduler: FAILED **");
    $finish;
  end

  task automatic send_beat(input logic [HourW-1:0] h, input logic [MinuteW-1:0] m);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_hour_of_day    <= h;
    in_minute_of_hour <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_time(h, m);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_setting(input logic [HourW-1:0] sh, input logic [MinuteW-1:0] sm,
                                 input logic [HourW-1:0] eh, input logic [MinuteW-1:0] em,
                                 input logic [CountW-1:0] run, input logic [CountW-1:0] cyc);
    write_reg(CfgWinStartHour, CfgW'(sh));
    write_reg(CfgWinStartMinute, CfgW'(sm));
    write_reg(CfgWinEndHour, CfgW'(eh));
    write_reg(CfgWinEndMinute, CfgW'(em));
    write_reg(CfgRunMinutes, run);
    write_reg(CfgCycleMinutes, cyc);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [HourW-1:0] rand_hour();
    return ($urandom_range(0, 7) == 0) ? HourW'($urandom_range(0, 31))
                                       : HourW'($urandom_range(0, 23));
  endfunction

  function automatic logic [MinuteW-1:0] rand_minute();
    return ($urandom_range(0, 7) == 0) ? MinuteW'($urandom_range(0, 63))
                                       : MinuteW'($urandom_range(0, 59));
  endfunction

  // a third of the beats land near a cycle boundary so wakes get hit
  function automatic void pick_time(output logic [HourW-1:0] h, output logic [MinuteW-1:0] m);
    int unsigned step;
    int unsigned t;
    if ($urandom_range(0, 2) == 0) begin
      step = sb.cycle_step();
      t = (sb.start_of_day() + step * $urandom_range(0, MinutesPerDay / step)
           + $urandom_range(0, 3)) % MinutesPerDay;
      h = HourW'(t / MinutesPerHour);
      m = MinuteW'(t % MinutesPerHour);
    end else begin
      h = rand_hour();
      m = rand_minute();
    end
  endfunction

  task automatic random_setting();
    logic [CountW-1:0] run;
    logic [CountW-1:0] cyc;
    case ($urandom_range(0, 7))
      0:       cyc = '0;
      1:       cyc = 11'd1;
      2:       cyc = CountW'(MinutesPerDay);
      3:       cyc = CountW'($urandom_range(0, 2047));
      default: cyc = CountW'($urandom_range(2, 180));
    endcase
    case ($urandom_range(0, 5))
      0:       run = '0;
      1:       run = '1;
      2:       run = CountW'($urandom_range(0, 2047));
      default: run = CountW'($urandom_range(0, int'(cyc)));
    endcase
    program_setting(rand_hour(), rand_minute(), rand_hour(), rand_minute(), run, cyc);
  endtask

  task automatic run_phase(input int beats, input bit gapless);
    int                 burst;
    logic [HourW-1:0]   h;
    logic [MinuteW-1:0] m;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < beats; i++) begin
      pick_time(h, m);
      send_beat(h, m);
      burst--;
      if (burst == 0) begin
        if (!gapless) pause_sender($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // spare indexes must leave the reset window alone
    write_reg(CfgSpareLo, '1);
    write_reg(CfgSpareHi, 11'h2AA);
    @(negedge clk);
    cfg_we <= 1'b0;

    // reset window 08:00-20:00, 5 of every 60 minutes
    send_beat(5'd0, 6'd0);
    send_beat(5'd7, 6'd59);
    send_beat(5'd8, 6'd0);
    send_beat(5'd8, 6'd5);
    send_beat(5'd9, 6'd4);
    send_beat(5'd20, 6'd0);
    send_beat(5'd20, 6'd1);
    send_beat(5'd31, 6'd63);
    drain();

    // wrapping window, zero cycle length, no run time
    program_setting(5'd22, 6'd0, 5'd2, 6'd30, 11'd0, 11'd0);
    send_beat(5'd23, 6'd0);
    send_beat(5'd1, 6'd0);
    send_beat(5'd2, 6'd31);
    send_beat(5'd23, 6'd59);
    drain();

    // out of range start, offset wraps, run as long as the cycle
    program_setting(5'd31, 6'd63, 5'd5, 6'd0, '1, '1);
    send_beat(5'd0, 6'd0);
    send_beat(5'd31, 6'd63);
    send_beat(5'd10, 6'd0);
    drain();

    // single minute window
    program_setting(5'd12, 6'd30, 5'd12, 6'd30, 11'd0, 11'd1);
    send_beat(5'd12, 6'd30);
    send_beat(5'd12, 6'd31);
    drain();

    // whole day, cycle of one day
    program_setting(5'd0, 6'd0, 5'd31, 6'd63, CountW'(MinutesPerDay), CountW'(MinutesPerDay));
    send_beat(5'd0, 6'd0);
    send_beat(5'd23, 6'd59);
    send_beat(5'd24, 6'd0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      random_setting();
      if (p == 3) hold_request = 1'b1;
      run_phase(PhaseBeats, (p == 3) || (p == 7));
      drain();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    $display("checked %0d time beats over %0d register settings with %0d long holds",
             sb.checked, settings_applied, long_holds);
    $display("%0d beats fell inside the window and %0d were wake times",
             sb.inside_hits, sb.wake_hits);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** duty_cycle_wake_scheduler: PASSED **");
    end else begin
      $display("** duty_cycle_wake_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
